### hw/rtl/ss_pkg.sv
// Shared types and constants for the stride scheduler.
package ss_pkg;
   localparam int NumTasks = 16;
   localparam int TaskW = 4;
   localparam int SliceW = 10;
   localparam int StrideW = 32;
   localparam int PrioW = 16;
   localparam int CountW = 5;
   localparam logic [StrideW-1:0] StrideBig = 32'h7FFF_FFFF;
   localparam int FifoDepth = 2;

   typedef enum logic [1:0] {
      ACT_ENQ = 2'd0, ACT_DEQ = 2'd1, ACT_PICK = 2'd2, ACT_TICK = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_QUEUED = 2'd2, ST_NOT_QUEUED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EX_IDLE, EX_SCAN, EX_DIV, EX_DONE
   } exec_state_type;

   typedef struct packed {
      action_type action;
      logic [TaskW-1:0] task_idx;
      logic [PrioW-1:0] prio;
   } cmd_type;
endpackage

### hw/rtl/ss_front.sv
// Front end: accepts request beats into a short command queue.
module ss_front import ss_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  cmd_type cmd_in,
   output logic cmd_valid,
   input  logic cmd_take,
   output cmd_type cmd_out
);
   cmd_type q_ff [FifoDepth];
   cmd_type q_in [FifoDepth];
   logic [1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == 2'(FifoDepth));
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_out = q_ff[0];
   assign do_push = push && !full;
   assign do_pop = cmd_take && cmd_valid;

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (do_pop) begin
         q_in[0] = q_ff[1];
      end
      if (do_push) begin
         if (do_pop) begin
            // A push beside a pop only happens with one entry held, so it lands at the head.
            q_in[~cnt_ff[0]] = cmd_in;
         end else begin
            q_in[cnt_ff[0]] = cmd_in;
         end
      end
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule

### hw/rtl/ss_back.sv
// Back end: slot table, minimum scan, serial divider and result register.
module ss_back import ss_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [SliceW-1:0] max_slice,
   input  logic cmd_valid,
   output logic cmd_take,
   input  cmd_type cmd,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [1:0] rsp_status,
   output logic [TaskW-1:0] rsp_picked_task,
   output logic rsp_resched,
   output logic [CountW-1:0] rsp_queued_count
);
   logic [NumTasks-1:0] queued_ff, queued_in;
   logic [StrideW-1:0] stride_ff [NumTasks];
   logic [PrioW-1:0] prio_ff [NumTasks];
   logic [SliceW-1:0] slice_ff [NumTasks];
   logic [CountW-1:0] total_ff, total_in;
   exec_state_type state_ff, state_in;
   logic [TaskW-1:0] idx_ff, idx_in, best_ff, best_in;
   logic found_ff, found_in;
   logic [4:0] bit_ff, bit_in;
   logic [StrideW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic out_valid_ff, out_valid_in;
   logic [1:0] o_status_ff, o_status_in;
   logic [TaskW-1:0] o_pick_ff, o_pick_in;
   logic o_resched_ff, o_resched_in;
   logic [CountW-1:0] o_count_ff, o_count_in;
   logic [StrideW-1:0] diff, rem_sh, inc;
   logic [PrioW-1:0] divisor;
   logic [SliceW-1:0] sl_cur, sl_dec;
   logic out_free, in_range, start;

   assign out_free = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_status = o_status_ff;
   assign rsp_picked_task = o_pick_ff;
   assign rsp_resched = o_resched_ff;
   assign rsp_queued_count = o_count_ff;
   assign in_range = 1'b1;  // the four-bit index always lies inside sixteen slots
   assign start = (state_ff == EX_IDLE) && cmd_valid && out_free;
   assign cmd_take = start;
   assign diff = stride_ff[idx_ff] - stride_ff[best_ff];
   assign divisor = (prio_ff[best_ff] == '0) ? PrioW'(1) : prio_ff[best_ff];
   assign rem_sh = {rem_ff[StrideW-2:0], StrideBig[bit_ff]};
   assign sl_cur = slice_ff[cmd.task_idx];
   assign sl_dec = (sl_cur != '0) ? sl_cur - SliceW'(1) : sl_cur;
   assign inc = quo_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EX_IDLE: if (start && cmd.action == ACT_PICK && total_ff != '0) state_in = EX_SCAN;
         EX_SCAN: if (idx_ff == TaskW'(NumTasks - 1)) state_in = EX_DIV;
         EX_DIV:  if (bit_ff == 5'd0) state_in = EX_DONE;
         EX_DONE: if (out_free) state_in = EX_IDLE;
         default: state_in = EX_IDLE;
      endcase
   end

   always_comb begin
      queued_in = queued_ff;
      total_in = total_ff;
      idx_in = idx_ff;
      best_in = best_ff;
      found_in = found_ff;
      bit_in = bit_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      o_status_in = o_status_ff;
      o_pick_in = o_pick_ff;
      o_resched_in = o_resched_ff;
      o_count_in = o_count_ff;
      case (state_ff)
         EX_IDLE: begin
            idx_in = '0;
            best_in = '0;
            found_in = 1'b0;
            if (start && !(cmd.action == ACT_PICK && total_ff != '0)) begin
               out_valid_in = 1'b1;
               o_status_in = ST_OK;
               o_pick_in = '0;
               o_resched_in = 1'b0;
               case (cmd.action)
                  ACT_PICK: o_status_in = ST_EMPTY;
                  ACT_ENQ: begin
                     if (!in_range) o_status_in = ST_NOT_QUEUED;
                     else if (queued_ff[cmd.task_idx]) o_status_in = ST_QUEUED;
                     else begin
                        queued_in[cmd.task_idx] = 1'b1;
                        total_in = total_ff + CountW'(1);
                     end
                  end
                  ACT_DEQ: begin
                     if (!in_range || !queued_ff[cmd.task_idx]) o_status_in = ST_NOT_QUEUED;
                     else begin
                        queued_in[cmd.task_idx] = 1'b0;
                        total_in = total_ff - CountW'(1);
                     end
                  end
                  ACT_TICK: o_resched_in = (sl_dec == '0);
                  default: o_status_in = ST_OK;
               endcase
               o_count_in = total_in;
            end
         end
         EX_SCAN: begin
            if (queued_ff[idx_ff] && (!found_ff || diff[StrideW-1])) begin
               best_in = idx_ff;
               found_in = 1'b1;
            end
            idx_in = idx_ff + TaskW'(1);
            bit_in = 5'(StrideW - 1);
            rem_in = '0;
            quo_in = '0;
         end
         EX_DIV: begin
            // Restoring division, one quotient bit per cycle, MSB first.
            if (rem_sh >= {16'd0, divisor}) begin
               rem_in = rem_sh - {16'd0, divisor};
               quo_in = {quo_ff[StrideW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[StrideW-2:0], 1'b0};
            end
            bit_in = bit_ff - 5'd1;
         end
         EX_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               o_status_in = ST_OK;
               o_pick_in = best_ff;
               o_resched_in = 1'b0;
               o_count_in = total_ff;
            end
         end
         default: out_valid_in = out_valid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EX_IDLE;
         queued_ff <= '0;
         total_ff <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NumTasks; i++) begin
            stride_ff[i] <= '0;
            slice_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         queued_ff <= queued_in;
         total_ff <= total_in;
         out_valid_ff <= out_valid_in;
         if (start && cmd.action == ACT_ENQ && !queued_ff[cmd.task_idx]) begin
            if (sl_cur == '0 || sl_cur > max_slice) slice_ff[cmd.task_idx] <= max_slice;
         end
         if (start && cmd.action == ACT_TICK) slice_ff[cmd.task_idx] <= sl_dec;
         if (state_ff == EX_DONE && out_free) stride_ff[best_ff] <= stride_ff[best_ff] + inc;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      best_ff <= best_in;
      found_ff <= found_in;
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      o_status_ff <= o_status_in;
      o_pick_ff <= o_pick_in;
      o_resched_ff <= o_resched_in;
      o_count_ff <= o_count_in;
      if (start && cmd.action == ACT_ENQ && !queued_ff[cmd.task_idx])
         prio_ff[cmd.task_idx] <= cmd.prio;
   end
endmodule

### hw/rtl/stride_scheduler_top.sv
// Top level of the stride scheduler.
// Usage: the request side is a queue write port. A beat (req_action,
// req_task_req, req_priority_req) is taken when push is high and
// full is low; a two-entry command queue absorbs beats while the
// back end is busy. The response side is a queue read port: the oldest
// result is on the rsp_ ports while empty is low and leaves on pop.
// Enqueue, dequeue, tick and an empty pick are answered when the back end
// takes the beat: the result is registered on that edge. A successful pick
// starts, scans all sixteen slots for the least stride, runs the
// bit-serial divider that forms 0x7FFFFFFF / priority, and then updates
// the stride and registers the result.
// The back end handles one beat at a time. If the receiver stalls, the
// finished result waits in the output register and the back end holds
// the next command; the command queue then fills and raises full.
// Synchronous reset clears all queued marks, strides, slices, the count
// and both queues, and sets max_slice to 5. csr_wr_en writes max_slice
// and should only be used while the block is idle.
module stride_scheduler_top import ss_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [1:0] req_action,
   input  logic [TaskW-1:0] req_task_req,
   input  logic [PrioW-1:0] req_priority_req,
   output logic empty,
   input  logic pop,
   output logic [1:0] rsp_status,
   output logic [TaskW-1:0] rsp_picked_task,
   output logic rsp_resched,
   output logic [CountW-1:0] rsp_queued_count,
   input  logic csr_wr_en,
   input  logic [SliceW-1:0] csr_wr_data
);
   logic [SliceW-1:0] max_slice_ff;
   cmd_type cmd_in, cmd_q;
   logic cmd_valid, cmd_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_slice_ff <= SliceW'(5);
      end else if (csr_wr_en) begin
         max_slice_ff <= csr_wr_data;
      end
   end

   assign cmd_in = '{action: action_type'(req_action), task_idx: req_task_req,
                     prio: req_priority_req};

   ss_front u_front (
      .clock, .reset, .push, .full, .cmd_in,
      .cmd_valid, .cmd_take, .cmd_out(cmd_q)
   );

   ss_back u_back (
      .clock, .reset, .max_slice(max_slice_ff), .cmd_valid, .cmd_take, .cmd(cmd_q),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_status, .rsp_picked_task,
      .rsp_resched, .rsp_queued_count
   );

   // A result can only report an empty table when the count is zero.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status == ST_EMPTY) |-> rsp_queued_count == '0)
      else $error("empty status with nonzero count");
   // Only a successful pick names a slot.
   a_pick_ok: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != ST_OK) |-> rsp_picked_task == '0)
      else $error("picked slot on failed action");
   // A waiting result that is not popped holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_status) && $stable(rsp_queued_count)))
      else $error("result changed while stalled");
endmodule

### verif/tb_stride_scheduler_top.sv
// Self-checking testbench for the stride scheduler top level.
`timescale 1ns / 1ps
module tb_stride_scheduler_top;
   import ss_pkg::*;

   typedef struct packed {
      logic [1:0] status;
      logic [TaskW-1:0] picked;
      logic resched;
      logic [CountW-1:0] count;
   } sched_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [1:0] req_action = '0;
   logic [TaskW-1:0] req_task_req = '0;
   logic [PrioW-1:0] req_priority_req = '0;
   logic empty;
   logic pop = 1'b0;
   logic [1:0] rsp_status;
   logic [TaskW-1:0] rsp_picked_task;
   logic rsp_resched;
   logic [CountW-1:0] rsp_queued_count;
   logic csr_wr_en = 1'b0;
   logic [SliceW-1:0] csr_wr_data = '0;

   stride_scheduler_top uut (
      .clock, .reset, .push, .full, .req_action, .req_task_req, .req_priority_req,
      .empty, .pop, .rsp_status, .rsp_picked_task, .rsp_resched, .rsp_queued_count,
      .csr_wr_en, .csr_wr_data
   );

   // Scheduler state mirror.
   logic mq [NumTasks];
   logic [StrideW-1:0] mstride [NumTasks];
   logic [PrioW-1:0] mprio [NumTasks];
   logic [SliceW-1:0] mslice [NumTasks];
   logic [CountW-1:0] mcount;
   logic [SliceW-1:0] mmax;

   sched_rsp_type pending_rsp [$];
   int errors = 0;
   int cycles = 0;
   bit calm = 1'b0;
   localparam int CycleLimit = 600000;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic sched_rsp_type schedule_step(logic [1:0] act, logic [3:0] tk,
                                                   logic [15:0] pr);
      sched_rsp_type r;
      int best;
      logic [StrideW-1:0] diff;
      logic [StrideW-1:0] inc;
      r = '0;
      best = -1;
      if (act == ACT_PICK) begin
         for (int i = 0; i < NumTasks; i++) begin
            if (mq[i]) begin
               if (best < 0) best = i;
               else begin
                  diff = mstride[i] - mstride[best];
                  if (diff[StrideW-1]) best = i;
               end
            end
         end
         if (best < 0) r.status = ST_EMPTY;
         else begin
            inc = (mprio[best] == 0) ? StrideBig : StrideBig / mprio[best];
            mstride[best] = mstride[best] + inc;
            r.picked = best[TaskW-1:0];
         end
      end else if (act == ACT_ENQ) begin
         if (mq[tk]) r.status = ST_QUEUED;
         else begin
            mq[tk] = 1'b1;
            mprio[tk] = pr;
            if (mslice[tk] == 0 || mslice[tk] > mmax) mslice[tk] = mmax;
            mcount = mcount + 1;
         end
      end else if (act == ACT_DEQ) begin
         if (!mq[tk]) r.status = ST_NOT_QUEUED;
         else begin
            mq[tk] = 1'b0;
            if (mcount > 0) mcount = mcount - 1;
         end
      end else begin
         if (mslice[tk] > 0) mslice[tk] = mslice[tk] - 1;
         r.resched = (mslice[tk] == 0);
      end
      r.count = mcount;
      return r;
   endfunction

   // Push stays high after the last beat until the next idle cycle or drain.
   task automatic send_beat(logic [1:0] act, logic [3:0] tk, logic [15:0] pr);
      while (!calm && $urandom_range(99) < 27) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_action <= act;
      req_task_req <= tk;
      req_priority_req <= pr;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_rsp.push_back(schedule_step(act, tk, pr));
   endtask

   // Response checker with random pop stalls.
   always @(posedge clock) begin
      sched_rsp_type e;
      sched_rsp_type a;
      if (!reset && pop && !empty) begin
         a = {rsp_status, rsp_picked_task, rsp_resched, rsp_queued_count};
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat %h", a);
         end else begin
            e = pending_rsp.pop_front();
            if (a !== e) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected st=%0d pk=%0d rs=%0d cnt=%0d,",
                           e.status, e.picked, e.resched, e.count,
                           " got st=%0d pk=%0d rs=%0d cnt=%0d",
                           a.status, a.picked, a.resched, a.count);
            end
         end
      end
      pop <= reset ? 1'b0 : (calm || $urandom_range(99) >= 27);
   end

   task automatic drain_all();
      push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_max_slice(logic [SliceW-1:0] v);
      drain_all();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mmax = v;
   endtask

   task automatic test_directed();
      send_beat(ACT_PICK, 0, 0);
      send_beat(ACT_DEQ, 3, 0);
      send_beat(ACT_TICK, 15, 0);
      send_beat(ACT_ENQ, 0, 16'h0000);
      send_beat(ACT_ENQ, 0, 16'h1234);
      send_beat(ACT_ENQ, 15, 16'hFFFF);
      send_beat(ACT_ENQ, 7, 16'h0001);
      send_beat(ACT_PICK, 0, 0);
      send_beat(ACT_PICK, 0, 0);
      send_beat(ACT_PICK, 0, 0);
      for (int i = 0; i < 7; i++) send_beat(ACT_TICK, 0, 0);
      send_beat(ACT_DEQ, 0, 0);
      send_beat(ACT_DEQ, 15, 0);
      send_beat(ACT_DEQ, 7, 0);
      send_beat(ACT_PICK, 0, 0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < NumTasks; i++) send_beat(ACT_ENQ, i, $urandom_range(3));
      for (int i = 0; i < 40; i++) send_beat(ACT_PICK, $urandom, $urandom);
      for (int i = 0; i < NumTasks; i++) send_beat(ACT_DEQ, i, 0);
   endtask

   task automatic test_random(int n);
      logic [1:0] act;
      logic [15:0] pr;
      for (int i = 0; i < n; i++) begin
         act = $urandom_range(3);
         // Picks are slow; keep them to roughly one beat in sixteen.
         if (act == ACT_PICK && $urandom_range(3) != 0) act = ACT_TICK;
         case ($urandom_range(3))
            0: pr = $urandom_range(3);
            1: pr = 16'hFFFF - $urandom_range(3);
            default: pr = $urandom;
         endcase
         send_beat(act, $urandom, pr);
      end
   endtask

   initial begin
      for (int i = 0; i < NumTasks; i++) begin
         mq[i] = 1'b0; mstride[i] = '0; mprio[i] = '0; mslice[i] = '0;
      end
      mcount = '0;
      mmax = 10'd5;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_max_slice(10'd1);
      test_full_table();
      test_random(400);
      write_max_slice(10'd1023);
      test_random(400);
      // Hold off the sender until the scheduler has gone idle.
      drain_all();
      calm = 1'b1;
      test_random(300);
      calm = 1'b0;
      write_max_slice(10'd3);
      test_random(400);
      write_max_slice(10'h2AA);
      test_random(350);
      drain_all();
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
